### rtl/core/radar_rim_point_unit_assert.svh
// ----------------------------------------------------------------------------
// Radar rim point assertion macros
// Clocked, reset-qualified property checks used by the rim point unit.
// ----------------------------------------------------------------------------
`ifndef RADAR_RIM_POINT_UNIT_ASSERT_SVH
`define RADAR_RIM_POINT_UNIT_ASSERT_SVH

// same-cycle implication
`define RRP_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define RRP_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/core/rrp_pkg.sv
// ----------------------------------------------------------------------------
// Radar rim point package
// Register indexes and fixed arithmetic constants.
// ----------------------------------------------------------------------------
package rrp_pkg;

  typedef enum logic [2:0] {
    CFG_CENTER_LAT = 3'd0,
    CFG_CENTER_LON = 3'd1,
    CFG_LON_SCALE  = 3'd2,
    CFG_LAT_SCALE  = 3'd3,
    CFG_SCREEN_X   = 3'd4,
    CFG_SCREEN_Y   = 3'd5,
    CFG_RING_LIMIT = 3'd6,
    CFG_RIM_RADIUS = 3'd7
  } cfg_idx_e;

  typedef struct packed {
    logic sx;   // east offset negative
    logic sy;   // north offset negative
    logic no;   // no rim point
  } tag_t;

  localparam logic [22:0] ScaleRst   = 23'd7295468;
  localparam logic [18:0] RoundHalf  = 19'd500000;
  // floor(2^47 / 15625): reciprocal for the divide by 1e6 after a shift by 6
  localparam logic [33:0] RecipM     = 34'd9007199254;
  localparam logic [13:0] DivK       = 14'd15625;
  localparam logic [18:0] TinySumMax = 19'd429496;
  localparam int          SqrtSteps  = 32;
  localparam int          DivSteps   = 11;
  localparam logic signed [14:0] OutMin = -15'sd4096;
  localparam logic signed [14:0] OutMax = 15'sd8191;

endpackage

### rtl/core/radar_rim_point_unit.sv
// ----------------------------------------------------------------------------
// Radar rim point unit: target lat/lon to rim point on a radar display
// Throughput: one beat per cycle unless the skid is full; 57-stage pipeline plus output reg and skid.
// Reset: clears valid bits and skid; config regs return to their reset values.
// ----------------------------------------------------------------------------
`include "radar_rim_point_unit_assert.svh"

module radar_rim_point_unit (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [2:0]          cfg_idx_i,
  input  logic [30:0]         cfg_data_i,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic signed [27:0]  target_latitude_i,
  input  logic signed [28:0]  target_longitude_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic                on_rim_o,
  output logic signed [13:0]  rim_x_o,
  output logic signed [13:0]  rim_y_o
);

  // Stage map:
  //   0      offsets from center, split into sign and magnitude
  //   1      magnitude times per-degree scale
  //   2      add rounding half, drop 6 bits (1e6 = 64 * 15625)
  //   3      reciprocal partial products for the divide by 15625
  //   4      sum partials -> quotient estimate (may be one low)
  //   5      estimate times 15625
  //   6      remainder check, fix estimate -> |dx|, |dy| in Q16 km
  //   7      squares, ring limit square, larger magnitude
  //   8      tiny / inside-ring decision, leading one position
  //   9      normalize so the larger magnitude sits in [2^30, 2^31)
  //   10     squares of normalized values
  //   11     sum of squares
  //   12-43  square root, one result bit per stage
  //   44     normalized magnitude times rim radius
  //   45-55  restoring divide by distance, one quotient bit per stage
  //   56     round half up on the remainder
  //   out    screen offset, saturation, output register + skid
  localparam int NS   = 57;
  localparam int LAST = NS - 1;
  localparam int SQ   = rrp_pkg::SqrtSteps;
  localparam int DV   = rrp_pkg::DivSteps;

  // ---------------- configuration registers ----------------
  logic signed [27:0] clat_q;
  logic signed [28:0] clon_q;
  logic [22:0]        lon_scale_q, lat_scale_q;
  logic [11:0]        scx_q, scy_q;
  logic [30:0]        ring_q;
  logic [10:0]        rim_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clat_q      <= '0;
      clon_q      <= '0;
      lon_scale_q <= rrp_pkg::ScaleRst;
      lat_scale_q <= rrp_pkg::ScaleRst;
      scx_q       <= '0;
      scy_q       <= '0;
      ring_q      <= '0;
      rim_q       <= '0;
    end else if (cfg_we_i) begin
      unique case (rrp_pkg::cfg_idx_e'(cfg_idx_i))
        rrp_pkg::CFG_CENTER_LAT: clat_q      <= signed'(cfg_data_i[27:0]);
        rrp_pkg::CFG_CENTER_LON: clon_q      <= signed'(cfg_data_i[28:0]);
        rrp_pkg::CFG_LON_SCALE:  lon_scale_q <= cfg_data_i[22:0];
        rrp_pkg::CFG_LAT_SCALE:  lat_scale_q <= cfg_data_i[22:0];
        rrp_pkg::CFG_SCREEN_X:   scx_q       <= cfg_data_i[11:0];
        rrp_pkg::CFG_SCREEN_Y:   scy_q       <= cfg_data_i[11:0];
        rrp_pkg::CFG_RING_LIMIT: ring_q      <= cfg_data_i[30:0];
        rrp_pkg::CFG_RIM_RADIUS: rim_q       <= cfg_data_i[10:0];
      endcase
    end
  end

  // ---------------- flow control ----------------
  // The whole pipe moves while the skid is empty; the output register
  // plus skid decouple it from out_ready_i, so input is taken while a
  // result waits.
  logic            adv;
  logic            k_full_q, out_v_q;
  logic [NS-1:0]   v_q;
  rrp_pkg::tag_t   tg_q [NS];
  rrp_pkg::tag_t   tag_in;
  logic            push, take;

  assign adv        = !k_full_q;
  assign in_ready_o = adv;
  assign push       = adv && v_q[LAST];
  assign take       = out_v_q && out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (adv) begin
      v_q <= {v_q[NS-2:0], in_valid_i};
    end
  end

  // ---------------- stage 0: offsets ----------------
  logic signed [29:0] dlon;
  logic signed [28:0] dlat;
  logic [29:0]        s0_ax_q;
  logic [28:0]        s0_ay_q;

  assign dlon = {target_longitude_i[28], target_longitude_i} - {clon_q[28], clon_q};
  assign dlat = {target_latitude_i[27], target_latitude_i} - {clat_q[27], clat_q};

  always_comb begin
    tag_in    = '0;
    tag_in.sx = dlon[29];
    tag_in.sy = dlat[28];
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s0_ax_q <= dlon[29] ? 30'(-dlon) : 30'(dlon);
      s0_ay_q <= dlat[28] ? 29'(-dlat) : 29'(dlat);
    end
  end

  // tags ride along every stage; stage 8 sets the no-rim flag
  logic s8_no;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      for (int k = 0; k < NS; k++) begin
        if (k == 0) begin
          tg_q[k] <= tag_in;
        end else if (k == 8) begin
          tg_q[k] <= '{sx: tg_q[k-1].sx, sy: tg_q[k-1].sy, no: s8_no};
        end else begin
          tg_q[k] <= tg_q[k-1];
        end
      end
    end
  end

  // ---------------- stages 1..6: scaled offsets ----------------
  logic [52:0] s1_px_q, s1_py_q;
  logic [46:0] s2_wx_q, s2_wy_q;
  logic [57:0] s3_phx_q, s3_plx_q, s3_phy_q, s3_ply_q;
  logic [46:0] s3_wx_q, s3_wy_q;
  logic [81:0] s4_sumx, s4_sumy;
  logic [33:0] s4_ex_q, s4_ey_q;
  logic [46:0] s4_wx_q, s4_wy_q;
  logic [47:0] s5_pex_q, s5_pey_q;
  logic [33:0] s5_ex_q, s5_ey_q;
  logic [46:0] s5_wx_q, s5_wy_q;
  logic [47:0] s6_remx, s6_remy;
  logic [33:0] s6_ax_q, s6_ay_q;

  assign s4_sumx = {s3_phx_q, 24'b0} + 82'(s3_plx_q);
  assign s4_sumy = {s3_phy_q, 24'b0} + 82'(s3_ply_q);
  assign s6_remx = 48'(s5_wx_q) - s5_pex_q;
  assign s6_remy = 48'(s5_wy_q) - s5_pey_q;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s1_px_q  <= 53'(s0_ax_q) * 53'(lon_scale_q);
      s1_py_q  <= 53'(s0_ay_q) * 53'(lat_scale_q);
      s2_wx_q  <= 47'((s1_px_q + 53'(rrp_pkg::RoundHalf)) >> 6);
      s2_wy_q  <= 47'((s1_py_q + 53'(rrp_pkg::RoundHalf)) >> 6);
      s3_phx_q <= 58'(s2_wx_q[46:24]) * 58'(rrp_pkg::RecipM);
      s3_plx_q <= 58'(s2_wx_q[23:0]) * 58'(rrp_pkg::RecipM);
      s3_phy_q <= 58'(s2_wy_q[46:24]) * 58'(rrp_pkg::RecipM);
      s3_ply_q <= 58'(s2_wy_q[23:0]) * 58'(rrp_pkg::RecipM);
      s3_wx_q  <= s2_wx_q;
      s3_wy_q  <= s2_wy_q;
      s4_ex_q  <= s4_sumx[80:47];
      s4_ey_q  <= s4_sumy[80:47];
      s4_wx_q  <= s3_wx_q;
      s4_wy_q  <= s3_wy_q;
      s5_pex_q <= 48'(s4_ex_q) * 48'(rrp_pkg::DivK);
      s5_pey_q <= 48'(s4_ey_q) * 48'(rrp_pkg::DivK);
      s5_ex_q  <= s4_ex_q;
      s5_ey_q  <= s4_ey_q;
      s5_wx_q  <= s4_wx_q;
      s5_wy_q  <= s4_wy_q;
      // estimate is at most one low
      s6_ax_q  <= (s6_remx >= 48'(rrp_pkg::DivK)) ? s5_ex_q + 34'd1 : s5_ex_q;
      s6_ay_q  <= (s6_remy >= 48'(rrp_pkg::DivK)) ? s5_ey_q + 34'd1 : s5_ey_q;
    end
  end

  // ---------------- stages 7..10: decision, normalize, squares ----------------
  logic        s7_big_q;
  logic [61:0] s7_sqx_q, s7_sqy_q, s7_sqr_q;
  logic [33:0] s7_m_q, s7_ax_q, s7_ay_q;
  logic [62:0] s8_sum;
  logic [5:0]  s8_pos, s8_pos_q;
  logic [33:0] s8_ax_q, s8_ay_q;
  logic [30:0] s9_nx_q, s9_ny_q;
  logic [61:0] s10_sqx_q, s10_sqy_q;
  logic [30:0] s10_nx_q, s10_ny_q;

  assign s8_sum = 63'(s7_sqx_q) + 63'(s7_sqy_q);
  // huge offsets always count as outside the ring
  assign s8_no  = !s7_big_q && ((s8_sum <= 63'(rrp_pkg::TinySumMax)) ||
                                (s8_sum <= 63'(s7_sqr_q)));

  always_comb begin
    s8_pos = '0;
    for (int i = 0; i < 34; i++) begin
      if (s7_m_q[i]) s8_pos = 6'(i);
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s7_big_q  <= (|s6_ax_q[33:31]) || (|s6_ay_q[33:31]);
      s7_sqx_q  <= 62'(s6_ax_q[30:0]) * 62'(s6_ax_q[30:0]);
      s7_sqy_q  <= 62'(s6_ay_q[30:0]) * 62'(s6_ay_q[30:0]);
      s7_sqr_q  <= 62'(ring_q) * 62'(ring_q);
      s7_m_q    <= (s6_ax_q > s6_ay_q) ? s6_ax_q : s6_ay_q;
      s7_ax_q   <= s6_ax_q;
      s7_ay_q   <= s6_ay_q;
      s8_pos_q  <= s8_pos;
      s8_ax_q   <= s7_ax_q;
      s8_ay_q   <= s7_ay_q;
      // value * 2^(30 - pos), truncating when pos > 30
      s9_nx_q   <= 31'({s8_ax_q, 30'b0} >> s8_pos_q);
      s9_ny_q   <= 31'({s8_ay_q, 30'b0} >> s8_pos_q);
      s10_sqx_q <= 62'(s9_nx_q) * 62'(s9_nx_q);
      s10_sqy_q <= 62'(s9_ny_q) * 62'(s9_ny_q);
      s10_nx_q  <= s9_nx_q;
      s10_ny_q  <= s9_ny_q;
    end
  end

  // ---------------- stages 11..43: square root ----------------
  // slot 0 is stage 11 (radicand); slot k+1 holds the state after step k
  logic [63:0] rt_v_q  [SQ+1];
  logic [63:0] rt_r_q  [SQ+1];
  logic [30:0] rt_nx_q [SQ+1];
  logic [30:0] rt_ny_q [SQ+1];

  always_ff @(posedge clk_i) begin
    if (adv) begin
      rt_v_q[0]  <= 64'(s10_sqx_q) + 64'(s10_sqy_q);
      rt_r_q[0]  <= '0;
      rt_nx_q[0] <= s10_nx_q;
      rt_ny_q[0] <= s10_ny_q;
    end
  end

  for (genvar k = 0; k < SQ; k++) begin : g_sqrt
    localparam logic [63:0] Bit = 64'd1 << (62 - 2 * k);
    logic [63:0] trial;
    logic        ge;

    assign trial = rt_r_q[k] + Bit;
    assign ge    = rt_v_q[k] >= trial;

    always_ff @(posedge clk_i) begin
      if (adv) begin
        rt_v_q[k+1]  <= ge ? rt_v_q[k] - trial : rt_v_q[k];
        rt_r_q[k+1]  <= ge ? (rt_r_q[k] >> 1) + Bit : rt_r_q[k] >> 1;
        rt_nx_q[k+1] <= rt_nx_q[k];
        rt_ny_q[k+1] <= rt_ny_q[k];
      end
    end
  end

  // ---------------- stages 44..55: divide by distance ----------------
  logic [41:0] dv_rx_q [DV+1];
  logic [41:0] dv_ry_q [DV+1];
  logic [10:0] dv_qx_q [DV+1];
  logic [10:0] dv_qy_q [DV+1];
  logic [31:0] dv_d_q  [DV+1];

  always_ff @(posedge clk_i) begin
    if (adv) begin
      dv_rx_q[0] <= 42'(rt_nx_q[SQ]) * 42'(rim_q);
      dv_ry_q[0] <= 42'(rt_ny_q[SQ]) * 42'(rim_q);
      dv_qx_q[0] <= '0;
      dv_qy_q[0] <= '0;
      dv_d_q[0]  <= rt_r_q[SQ][31:0];
    end
  end

  for (genvar i = 0; i < DV; i++) begin : g_div
    localparam int Sh = DV - 1 - i;
    logic [42:0] dd;
    logic        gx, gy;
    logic [10:0] qx_n, qy_n;

    assign dd = 43'(dv_d_q[i]) << Sh;
    assign gx = {1'b0, dv_rx_q[i]} >= dd;
    assign gy = {1'b0, dv_ry_q[i]} >= dd;

    always_comb begin
      qx_n     = dv_qx_q[i];
      qy_n     = dv_qy_q[i];
      qx_n[Sh] = gx;
      qy_n[Sh] = gy;
    end

    always_ff @(posedge clk_i) begin
      if (adv) begin
        dv_rx_q[i+1] <= gx ? 42'({1'b0, dv_rx_q[i]} - dd) : dv_rx_q[i];
        dv_ry_q[i+1] <= gy ? 42'({1'b0, dv_ry_q[i]} - dd) : dv_ry_q[i];
        dv_qx_q[i+1] <= qx_n;
        dv_qy_q[i+1] <= qy_n;
        dv_d_q[i+1]  <= dv_d_q[i];
      end
    end
  end

  // ---------------- stage 56: rounding ----------------
  logic [11:0] s56_qx_q, s56_qy_q;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s56_qx_q <= 12'(dv_qx_q[DV]) +
                  (({dv_rx_q[DV], 1'b0} >= 43'(dv_d_q[DV])) ? 12'd1 : 12'd0);
      s56_qy_q <= 12'(dv_qy_q[DV]) +
                  (({dv_ry_q[DV], 1'b0} >= 43'(dv_d_q[DV])) ? 12'd1 : 12'd0);
    end
  end

  // ---------------- result: screen point, saturation ----------------
  logic signed [14:0] qx_s, qy_s, base_x, base_y, raw_x, raw_y, sat_x, sat_y;
  logic               new_on;
  logic signed [13:0] new_x, new_y;

  assign qx_s   = signed'(15'(s56_qx_q));
  assign qy_s   = signed'(15'(s56_qy_q));
  assign base_x = signed'({3'b000, scx_q});
  assign base_y = signed'({3'b000, scy_q});
  assign raw_x  = base_x + (tg_q[LAST].sx ? -qx_s : qx_s);
  // screen y grows downward
  assign raw_y  = base_y - (tg_q[LAST].sy ? -qy_s : qy_s);

  always_comb begin
    priority if (raw_x < rrp_pkg::OutMin) sat_x = rrp_pkg::OutMin;
    else if (raw_x > rrp_pkg::OutMax)     sat_x = rrp_pkg::OutMax;
    else                                  sat_x = raw_x;
    priority if (raw_y < rrp_pkg::OutMin) sat_y = rrp_pkg::OutMin;
    else if (raw_y > rrp_pkg::OutMax)     sat_y = rrp_pkg::OutMax;
    else                                  sat_y = raw_y;
  end

  assign new_on = !tg_q[LAST].no;
  assign new_x  = new_on ? 14'(sat_x) : 14'sd0;
  assign new_y  = new_on ? 14'(sat_y) : 14'sd0;

  // ---------------- output register and skid ----------------
  logic               r_on_q, k_on_q;
  logic signed [13:0] r_x_q, r_y_q, k_x_q, k_y_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q  <= 1'b0;
      k_full_q <= 1'b0;
    end else if (take) begin
      if (k_full_q) k_full_q <= 1'b0;
      else          out_v_q  <= push;
    end else if (push) begin
      if (out_v_q) k_full_q <= 1'b1;
      else         out_v_q  <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take && k_full_q) begin
      r_on_q <= k_on_q;
      r_x_q  <= k_x_q;
      r_y_q  <= k_y_q;
    end else if (push && (take || !out_v_q)) begin
      r_on_q <= new_on;
      r_x_q  <= new_x;
      r_y_q  <= new_y;
    end
    if (push && out_v_q && !take) begin
      k_on_q <= new_on;
      k_x_q  <= new_x;
      k_y_q  <= new_y;
    end
  end

  assign out_valid_o = out_v_q;
  assign on_rim_o    = r_on_q;
  assign rim_x_o     = r_x_q;
  assign rim_y_o     = r_y_q;

  // ---------------- assertions ----------------
  `RRP_ASSERT_IMP(a_norim_zero, out_valid_o && !on_rim_o,
                  rim_x_o == 14'sd0 && rim_y_o == 14'sd0, "no rim point but nonzero x or y")
  `RRP_ASSERT_IMP(a_skid_needs_out, k_full_q, out_v_q, "skid holds a beat with output empty")
  `RRP_ASSERT_NXT(a_accept_loads, in_valid_i && in_ready_o, v_q[0],
                  "accepted beat missing from first stage")
  `RRP_ASSERT_NXT(a_skid_holds, k_full_q && !out_ready_i, k_full_q,
                  "skid dropped a beat while output stalled")

endmodule
